// ===== rtl/varint_field_decoder_defines.svh =====
// assertion macros used by the varint field decoder checker
// no dependencies
`ifndef VARINT_FIELD_DECODER_DEFINES_SVH
`define VARINT_FIELD_DECODER_DEFINES_SVH

// checked only while out of reset
`define VFD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define VFD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/vfd_pkg.sv =====
// types and constants of the varint field decoder
// no dependencies
package vfd_pkg;

  localparam logic [2:0] HEADER_BYTES = 3'd4;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TAG    = 2'd1,
    PH_VARINT = 2'd2,
    PH_STOP   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_CLEAN    = 3'd0,
    ST_BADWIRE  = 3'd1,
    ST_OVERLONG = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_SHORT    = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        field_valid;
    logic [4:0]  field_id;
    logic [31:0] field_value;
    logic        packet_end;
    logic [2:0]  end_status;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  header_count;
    phase_e      phase;
    logic [4:0]  held_field_number;
    logic [31:0] value_accumulator;
    logic [2:0]  group_count;
    status_e     stop_status;
  } vfd_state_t;

  localparam vfd_state_t STATE_RESET = '{
    header_count:      3'd0,
    phase:             PH_HEADER,
    held_field_number: 5'd0,
    value_accumulator: 32'd0,
    group_count:       3'd0,
    stop_status:       ST_CLEAN
  };

endpackage

// ===== rtl/varint_field_decoder.sv =====
// varint field decoder top level: input register, byte decode, result register
// depends on vfd_pkg and vfd_step
// a byte is accepted into the input register; its result is then written to the result register
// throughput: one byte per cycle; the input stalls only when the result register is held
// reset: asynchronous, active low; clears both valid bits and the decode state
module varint_field_decoder
  import vfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic       s1_valid_q;
  in_item_t   s1_data_q;
  vfd_state_t st_q;
  vfd_state_t st_d;
  out_item_t  step_res;
  logic       step_emit;
  logic       out_valid_q;
  out_item_t  out_data_q;
  logic       out_free;
  logic       s1_go;
  logic       in_take;

  vfd_step u_step (
    .st_i   (st_q),
    .item_i (s1_data_q),
    .st_o   (st_d),
    .res_o  (step_res),
    .emit_o (step_emit)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!step_emit || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= STATE_RESET;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_go) begin
        st_q <= st_d;
      end
      if (s1_go && step_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_data_i;
    end
    if (s1_go && step_emit) begin
      out_data_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/vfd_step.sv =====
// next-state and result logic for one packet byte
// depends on vfd_pkg
module vfd_step
  import vfd_pkg::*;
(
  input  vfd_state_t st_i,
  input  in_item_t   item_i,
  output vfd_state_t st_o,
  output out_item_t  res_o,
  output logic       emit_o
);

  phase_e      phase;
  logic [2:0]  hdr_cnt;
  logic [2:0]  grp_idx;
  logic [2:0]  grp_next;
  logic [31:0] grp_bits;
  logic [31:0] acc;
  logic        fvalid;
  status_e     status;
  logic [7:0]  b;

  assign b = item_i.byte_value;

  // place the low seven bits at the group's shift (only the low four bits for the fifth group)
  always_comb begin
    grp_idx = (st_i.group_count > 3'd4) ? 3'd4 : st_i.group_count;
    case (grp_idx)
      3'd0:    grp_bits = {25'd0, b[6:0]};
      3'd1:    grp_bits = {18'd0, b[6:0], 7'd0};
      3'd2:    grp_bits = {11'd0, b[6:0], 14'd0};
      3'd3:    grp_bits = {4'd0, b[6:0], 21'd0};
      default: grp_bits = {b[3:0], 28'd0};
    endcase
    acc      = st_i.value_accumulator | grp_bits;
    grp_next = grp_idx + 3'd1;
    hdr_cnt  = st_i.header_count + 3'd1;
  end

  always_comb begin
    st_o   = st_i;
    fvalid = 1'b0;
    status = ST_CLEAN;
    phase  = st_i.phase;
    if (phase == PH_HEADER && st_i.header_count >= HEADER_BYTES) begin
      phase = PH_TAG;
    end
    st_o.phase = phase;
    case (phase)
      PH_HEADER: begin
        st_o.header_count = hdr_cnt;
        if (hdr_cnt >= HEADER_BYTES) begin
          st_o.phase = PH_TAG;
        end
        status = ST_SHORT;
      end
      PH_TAG: begin
        if (b[2:0] != 3'd0) begin
          st_o.phase       = PH_STOP;
          st_o.stop_status = ST_BADWIRE;
          status           = ST_BADWIRE;
        end else begin
          st_o.held_field_number = b[7:3];
          st_o.value_accumulator = 32'd0;
          st_o.group_count       = 3'd0;
          st_o.phase             = PH_VARINT;
          status                 = ST_TRUNC;
        end
      end
      PH_VARINT: begin
        st_o.value_accumulator = acc;
        if (!b[7]) begin
          fvalid           = 1'b1;
          st_o.group_count = grp_idx;
          st_o.phase       = PH_TAG;
          status           = ST_CLEAN;
        end else begin
          st_o.group_count = grp_next;
          if (grp_next >= 3'd5) begin
            st_o.phase       = PH_STOP;
            st_o.stop_status = ST_OVERLONG;
            status           = ST_OVERLONG;
          end else begin
            status = ST_TRUNC;
          end
        end
      end
      default: begin
        status = st_i.stop_status;
      end
    endcase
    if (item_i.last_byte) begin
      st_o = STATE_RESET;
    end
  end

  always_comb begin
    res_o.field_valid = fvalid;
    res_o.field_id    = fvalid ? st_i.held_field_number : 5'd0;
    res_o.field_value = fvalid ? acc : 32'd0;
    res_o.packet_end  = item_i.last_byte;
    res_o.end_status  = item_i.last_byte ? status : ST_CLEAN;
    emit_o            = fvalid | item_i.last_byte;
  end

endmodule

// ===== rtl/vfd_checker.sv =====
// port-level checks of the varint field decoder, bound to the top level
// depends on vfd_pkg and varint_field_decoder_defines.svh
`include "varint_field_decoder_defines.svh"
module vfd_checker
  import vfd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic out_held;
  logic no_field;
  logic field_clear;
  logic status_ok;

  assign out_held    = out_valid_o && out_stall_i;
  assign no_field    = out_valid_o && !out_data_o.field_valid;
  assign field_clear = (out_data_o.field_id == 5'd0) && (out_data_o.field_value == 32'd0);
  assign status_ok   = (out_data_o.packet_end || out_data_o.end_status == ST_CLEAN) &&
                       (out_data_o.end_status <= ST_SHORT);

  `VFD_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !out_valid_o, "result during reset")
  `VFD_ASSERT(a_result_held, out_held |=> out_valid_o && $stable(out_data_o), "result not held")
  `VFD_ASSERT(a_result_has_cause, no_field |-> out_data_o.packet_end, "empty result")
  `VFD_ASSERT(a_idle_field_zero, no_field |-> field_clear, "field data without field")
  `VFD_ASSERT(a_status_legal, out_valid_o |-> status_ok, "bad end status")

endmodule

bind varint_field_decoder vfd_checker u_vfd_checker (.*);
